/* design/ccpt_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the circumcircle point test pipeline.
// No dependencies; used by the top level and its port checker.
package ccpt_pkg;

  // Default coordinate width of every input field.
  localparam int COORD_BITS_DEF = 16;

  // Register stages from input to output, the output register included.
  localparam int PIPE_DEPTH = 6;

endpackage

/* design/circumcircle_point_test.sv */
`timescale 1ns / 1ps
// Circumcircle point test: exact in-circle determinant, six-stage pipeline.
// Depends on ccpt_pkg (default coordinate width).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in_     | in        | in_valid / in_stall  | corners a, b, c and query point, x and y
//  out_    | out       | out_valid / out_stall| out_inside_res, out_degenerate
//
// One transaction per clock sustained while out_stall is low. Six register
// stages: differences, products, sums, partial products, term recombination,
// and the final sum into the output register. A result is offered on out_valid
// from the output register and leaves it while out_stall is low.
// rst_n is synchronous, active low, and clears every stage valid bit.
// Each stage holds while the stage after it is full and held; an empty stage
// keeps loading, so bubbles close up behind a stalled output register.
// in_stall is high only when every stage holds a transaction and the output
// is stalled.
module circumcircle_point_test #(
  parameter int COORD_BITS = ccpt_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_corner_a_x,
  input  logic [COORD_BITS-1:0] in_corner_a_y,
  input  logic [COORD_BITS-1:0] in_corner_b_x,
  input  logic [COORD_BITS-1:0] in_corner_b_y,
  input  logic [COORD_BITS-1:0] in_corner_c_x,
  input  logic [COORD_BITS-1:0] in_corner_c_y,
  input  logic [COORD_BITS-1:0] in_query_x,
  input  logic [COORD_BITS-1:0] in_query_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_inside_res,
  output logic                  out_degenerate
);

  // Widths. W-bit coordinates give (W+1)-bit differences whose squares stay
  // below 2^(2W), so a sum of two squares fits 2W+1 unsigned bits and a
  // cross term fits 2W+2 signed bits. The final product is split at H bits.
  localparam int W    = COORD_BITS;
  localparam int PW   = 2 * W + 2;   // full signed product of two differences
  localparam int SQW  = 2 * W;       // one square, unsigned
  localparam int PRW  = 2 * W + 1;   // one cross product, signed
  localparam int D2W  = 2 * W + 1;   // squared distance, unsigned
  localparam int CRW  = 2 * W + 2;   // cross term / orientation, signed
  localparam int H    = W + 1;       // split point of the wide product
  localparam int DHW  = D2W - H;     // high half of squared distance
  localparam int CHW  = CRW - H;     // high half of cross term, signed
  localparam int LLW  = 2 * H;
  localparam int LHW  = H + 1 + CHW;
  localparam int HLW  = DHW + H;
  localparam int HHW  = DHW + 1 + CHW;
  localparam int TW   = 4 * W + 3;   // one determinant term, signed
  localparam int DETW = 4 * W + 5;   // determinant, signed

  // ---------------------------------------------------------------------
  // Stage flow control: a stage loads when empty or when its successor loads.
  // ---------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_valid_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt, s5_v_nxt, out_valid_nxt;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !out_valid_r || !out_stall;
  assign rdy5 = !s5_v_r || rdy6;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_stall = !rdy1;

  always_comb begin
    s1_v_nxt      = rdy1 ? in_valid    : s1_v_r;
    s2_v_nxt      = rdy2 ? s1_v_r      : s2_v_r;
    s3_v_nxt      = rdy3 ? s2_v_r      : s3_v_r;
    s4_v_nxt      = rdy4 ? s3_v_r      : s4_v_r;
    s5_v_nxt      = rdy5 ? s4_v_r      : s5_v_r;
    out_valid_nxt = rdy6 ? s5_v_r      : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      s3_v_r      <= s3_v_nxt;
      s4_v_r      <= s4_v_nxt;
      s5_v_r      <= s5_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: coordinates relative to the query point, and the two triangle
  // edges from corner a for the orientation. Index 0, 1, 2 = corner a, b, c.
  // ---------------------------------------------------------------------
  logic [W-1:0]        cx_in [3];
  logic [W-1:0]        cy_in [3];
  logic signed [W:0]   s1_dx_r [3];
  logic signed [W:0]   s1_dy_r [3];
  logic signed [W:0]   s1_ebx_r, s1_eby_r, s1_ecx_r, s1_ecy_r;

  assign cx_in[0] = in_corner_a_x;
  assign cx_in[1] = in_corner_b_x;
  assign cx_in[2] = in_corner_c_x;
  assign cy_in[0] = in_corner_a_y;
  assign cy_in[1] = in_corner_b_y;
  assign cy_in[2] = in_corner_c_y;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        s1_dx_r[i] <= $signed({cx_in[i][W-1], cx_in[i]} - {in_query_x[W-1], in_query_x});
        s1_dy_r[i] <= $signed({cy_in[i][W-1], cy_in[i]} - {in_query_y[W-1], in_query_y});
      end
      s1_ebx_r <= $signed({in_corner_b_x[W-1], in_corner_b_x}
                          - {in_corner_a_x[W-1], in_corner_a_x});
      s1_eby_r <= $signed({in_corner_b_y[W-1], in_corner_b_y}
                          - {in_corner_a_y[W-1], in_corner_a_y});
      s1_ecx_r <= $signed({in_corner_c_x[W-1], in_corner_c_x}
                          - {in_corner_a_x[W-1], in_corner_a_x});
      s1_ecy_r <= $signed({in_corner_c_y[W-1], in_corner_c_y}
                          - {in_corner_a_y[W-1], in_corner_a_y});
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: all narrow products. For term i the cross product pairs the
  // two other corners in cyclic order (b,c for a; c,a for b; a,b for c).
  // ---------------------------------------------------------------------
  logic signed [PW-1:0]  sqx_full [3];
  logic signed [PW-1:0]  sqy_full [3];
  logic signed [PW-1:0]  crp_full [3];
  logic signed [PW-1:0]  crn_full [3];
  logic signed [PW-1:0]  op1_full, op2_full;
  logic [SQW-1:0]        s2_sqx_r [3];
  logic [SQW-1:0]        s2_sqy_r [3];
  logic [PRW-1:0]        s2_crp_r [3];
  logic [PRW-1:0]        s2_crn_r [3];
  logic [PRW-1:0]        s2_op1_r, s2_op2_r;

  for (genvar g = 0; g < 3; g++) begin : g_prod
    localparam int J = (g == 2) ? 0 : g + 1;
    localparam int K = (g == 0) ? 2 : g - 1;
    assign sqx_full[g] = PW'(s1_dx_r[g]) * PW'(s1_dx_r[g]);
    assign sqy_full[g] = PW'(s1_dy_r[g]) * PW'(s1_dy_r[g]);
    assign crp_full[g] = PW'(s1_dx_r[J]) * PW'(s1_dy_r[K]);
    assign crn_full[g] = PW'(s1_dy_r[J]) * PW'(s1_dx_r[K]);
  end

  assign op1_full = PW'(s1_ebx_r) * PW'(s1_ecy_r);
  assign op2_full = PW'(s1_eby_r) * PW'(s1_ecx_r);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        s2_sqx_r[i] <= sqx_full[i][SQW-1:0];
        s2_sqy_r[i] <= sqy_full[i][SQW-1:0];
        s2_crp_r[i] <= crp_full[i][PRW-1:0];
        s2_crn_r[i] <= crn_full[i][PRW-1:0];
      end
      s2_op1_r <= op1_full[PRW-1:0];
      s2_op2_r <= op2_full[PRW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: squared distances, cross terms and the orientation sign.
  // ---------------------------------------------------------------------
  logic [D2W-1:0] s3_d2_r [3];
  logic [CRW-1:0] s3_cr_r [3];
  logic [CRW-1:0] orient;
  logic           s3_oz_r, s3_on_r;

  assign orient = {s2_op1_r[PRW-1], s2_op1_r} - {s2_op2_r[PRW-1], s2_op2_r};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int i = 0; i < 3; i++) begin
        s3_d2_r[i] <= {1'b0, s2_sqx_r[i]} + {1'b0, s2_sqy_r[i]};
        s3_cr_r[i] <= {s2_crp_r[i][PRW-1], s2_crp_r[i]}
                      - {s2_crn_r[i][PRW-1], s2_crn_r[i]};
      end
      s3_oz_r <= (orient == '0);
      s3_on_r <= orient[CRW-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: squared distance times cross term as four partial products.
  // The distance is unsigned; the cross term's high half carries its sign.
  // ---------------------------------------------------------------------
  logic [H-1:0]             dlo [3];
  logic [DHW-1:0]           dhi [3];
  logic [H-1:0]             clo [3];
  logic signed [CHW-1:0]    chi [3];
  logic [LLW-1:0]           pll [3];
  logic signed [LHW-1:0]    plh [3];
  logic [HLW-1:0]           phl [3];
  logic signed [HHW-1:0]    phh [3];
  logic [LLW-1:0]           s4_ll_r [3];
  logic [LHW-1:0]           s4_lh_r [3];
  logic [HLW-1:0]           s4_hl_r [3];
  logic [HHW-1:0]           s4_hh_r [3];
  logic                     s4_oz_r, s4_on_r;

  for (genvar g = 0; g < 3; g++) begin : g_part
    assign dlo[g] = s3_d2_r[g][H-1:0];
    assign dhi[g] = s3_d2_r[g][D2W-1:H];
    assign clo[g] = s3_cr_r[g][H-1:0];
    assign chi[g] = $signed(s3_cr_r[g][CRW-1:H]);
    assign pll[g] = LLW'(dlo[g]) * LLW'(clo[g]);
    assign plh[g] = LHW'($signed({1'b0, dlo[g]})) * LHW'(chi[g]);
    assign phl[g] = HLW'(dhi[g]) * HLW'(clo[g]);
    assign phh[g] = HHW'($signed({1'b0, dhi[g]})) * HHW'(chi[g]);
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < 3; i++) begin
        s4_ll_r[i] <= pll[i];
        s4_lh_r[i] <= plh[i];
        s4_hl_r[i] <= phl[i];
        s4_hh_r[i] <= phh[i];
      end
      s4_oz_r <= s3_oz_r;
      s4_on_r <= s3_on_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: recombine each term; it fits TW bits so wrap-around is exact.
  // ---------------------------------------------------------------------
  logic [TW-1:0] term [3];
  logic [TW-1:0] s5_term_r [3];
  logic          s5_oz_r, s5_on_r;

  for (genvar g = 0; g < 3; g++) begin : g_term
    assign term[g] = ({{(TW-HHW){s4_hh_r[g][HHW-1]}}, s4_hh_r[g]} << (2 * H))
                   + (({{(TW-LHW){s4_lh_r[g][LHW-1]}}, s4_lh_r[g]}
                       + {{(TW-HLW){1'b0}}, s4_hl_r[g]}) << H)
                   + {{(TW-LLW){1'b0}}, s4_ll_r[g]};
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      for (int i = 0; i < 3; i++) begin
        s5_term_r[i] <= term[i];
      end
      s5_oz_r <= s4_oz_r;
      s5_on_r <= s4_on_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: sum the terms and decide. On the circle counts as inside;
  // collinear corners report degenerate and not inside.
  // ---------------------------------------------------------------------
  logic [DETW-1:0] det;
  logic            det_zero;
  logic            inside_nxt;
  logic            out_inside_res_r, out_degenerate_r;

  assign det = {{(DETW-TW){s5_term_r[0][TW-1]}}, s5_term_r[0]}
             + {{(DETW-TW){s5_term_r[1][TW-1]}}, s5_term_r[1]}
             + {{(DETW-TW){s5_term_r[2][TW-1]}}, s5_term_r[2]};
  assign det_zero   = (det == '0);
  assign inside_nxt = !s5_oz_r && (det_zero || (det[DETW-1] == s5_on_r));

  always_ff @(posedge clk) begin
    if (rdy6) begin
      out_inside_res_r <= inside_nxt;
      out_degenerate_r <= s5_oz_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;
  assign out_degenerate = out_degenerate_r;

endmodule

/* design/ccpt_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for circumcircle_point_test, with its bind statement.
// Depends on ccpt_pkg (pipeline depth).
module ccpt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_inside_res,
  input logic out_degenerate
);

  localparam int CNTW = $clog2(ccpt_pkg::PIPE_DEPTH + 1) + 1;

  logic            in_acc, out_acc;
  logic [CNTW-1:0] flight_r, flight_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    flight_nxt = flight_r;
    if (in_acc && !out_acc) begin
      flight_nxt = flight_r + CNTW'(1);
    end else if (out_acc && !in_acc) begin
      flight_nxt = flight_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
    end else begin
      flight_r <= flight_nxt;
    end
  end

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // No result without an outstanding transaction.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (flight_r != '0))
    else $error("result without a pending transaction");

  // Never more transactions in flight than there are stages.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flight_r <= CNTW'(ccpt_pkg::PIPE_DEPTH))
    else $error("more transactions in flight than stages");

  // Hold a stalled result.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inside_res)
                               && $stable(out_degenerate))
    else $error("stalled result changed");

  // Collinear corners never report inside.
  a_degen_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_inside_res)
    else $error("degenerate result flagged inside");

endmodule

bind circumcircle_point_test ccpt_checker u_ccpt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_inside_res (out_inside_res),
  .out_degenerate (out_degenerate)
);
